@@ src/drus_pkg.sv @@
// shared types and constants of the dual ultrasonic ranger scheduler
package drus_pkg;

	localparam int PING_W   = 20;
	localparam int TIMER_W  = 16;
	localparam int RANGE_W  = 15;
	localparam int PULSE_W  = 4;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam int TRIGGER_PULSE_TICKS_DEF = 10;
	localparam int RANGE_FRACTION_BITS_DEF = 4;
	localparam int RANGE_FRACTION_BITS_MAX = 6;

	localparam logic [PING_W-1:0]  PING_MAX      = '1;
	localparam logic [TIMER_W-1:0] TIMER_MAX     = '1;
	localparam logic [RANGE_W-1:0] RANGE_MAX     = '1;
	localparam logic [PING_W-1:0]  PING_RESET    = 20'd100000;
	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd30000;

	// x / 58 is (x >> 1) / 29; reciprocal of 29 exact for operands below 2^21
	localparam int RECIP_W     = 22;
	localparam int RECIP_SHIFT = 26;
	localparam logic [RECIP_W-1:0] RECIP_29 = 22'd2314099;

	typedef enum logic [0:0] {
		REG_PING_INTERVAL = 1'b0,
		REG_ECHO_TIMEOUT  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PING_W-1:0]  ping_interval;
		logic [TIMER_W-1:0] echo_timeout;
	} cfg_t;

	typedef struct packed {
		logic               trig_left;
		logic               trig_right;
		logic [RANGE_W-1:0] left_range;
		logic               left_valid;
		logic [RANGE_W-1:0] right_range;
		logic               right_valid;
		logic               range_update;
	} result_t;

endpackage

@@ src/drus_range.sv @@
// echo duration to distance: duration * 2^frac / 58, truncated and saturated
module drus_range #(
	parameter int RANGE_FRACTION_BITS = drus_pkg::RANGE_FRACTION_BITS_DEF
) (
	input  logic [drus_pkg::TIMER_W-1:0] duration,
	output logic [drus_pkg::RANGE_W-1:0] range
);

	localparam int XW = drus_pkg::TIMER_W + RANGE_FRACTION_BITS;
	localparam int YW = XW - 1;
	localparam int PW = YW + drus_pkg::RECIP_W;
	localparam int QW = PW - drus_pkg::RECIP_SHIFT;
	localparam int EW = (QW > drus_pkg::RANGE_W) ? QW : drus_pkg::RANGE_W;

	logic [XW-1:0] scaled;
	logic [YW-1:0] half;
	logic [PW-1:0] prod;
	logic [QW-1:0] quot;
	logic [EW-1:0] quot_ext;

	assign scaled   = XW'(duration) << RANGE_FRACTION_BITS;
	assign half     = scaled[XW-1:1];
	assign prod     = PW'(half) * PW'(drus_pkg::RECIP_29);
	assign quot     = prod[PW-1:drus_pkg::RECIP_SHIFT];
	assign quot_ext = EW'(quot);

	always_comb begin
		if (quot_ext > EW'(drus_pkg::RANGE_MAX)) begin
			range = drus_pkg::RANGE_MAX;
		end else begin
			range = quot_ext[drus_pkg::RANGE_W-1:0];
		end
	end

endmodule

@@ src/drus_sched.sv @@
// ping scheduler, echo timer, timeout and per-side range stores
module drus_sched #(
	parameter int TRIGGER_PULSE_TICKS = drus_pkg::TRIGGER_PULSE_TICKS_DEF,
	parameter int RANGE_FRACTION_BITS = drus_pkg::RANGE_FRACTION_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              echo,
	input  drus_pkg::cfg_t    cfg,
	output drus_pkg::result_t res
);

	logic [drus_pkg::PING_W-1:0]  since_ping_q,    since_ping_d;
	logic [drus_pkg::TIMER_W-1:0] since_trig_q,    since_trig_d;
	logic [drus_pkg::PULSE_W-1:0] pulse_q,         pulse_d;
	logic                         await_q,         await_d;
	logic                         side_right_q,    side_right_d;
	logic                         next_right_q,    next_right_d;
	logic                         prev_echo_q,     prev_echo_d;
	logic [drus_pkg::TIMER_W-1:0] dur_q,           dur_d;
	logic [drus_pkg::RANGE_W-1:0] left_q,          left_d;
	logic [drus_pkg::RANGE_W-1:0] right_q,         right_d;
	logic                         left_ok_q,       left_ok_d;
	logic                         right_ok_q,      right_ok_d;
	logic [drus_pkg::RANGE_W-1:0] new_range;
	logic [drus_pkg::PING_W-1:0]  interval;
	logic                         tl, tr;

	drus_range #(
		.RANGE_FRACTION_BITS(RANGE_FRACTION_BITS)
	) u_range (
		.duration(dur_q),
		.range   (new_range)
	);

	assign interval = (cfg.ping_interval == '0) ? drus_pkg::PING_W'(1) : cfg.ping_interval;

	always_comb begin
		since_ping_d = since_ping_q;
		since_trig_d = since_trig_q;
		pulse_d      = pulse_q;
		await_d      = await_q;
		side_right_d = side_right_q;
		next_right_d = next_right_q;
		dur_d        = dur_q;
		left_d       = left_q;
		right_d      = right_q;
		left_ok_d    = left_ok_q;
		right_ok_d   = right_ok_q;
		tl           = 1'b0;
		tr           = 1'b0;

		// echo edges
		if (echo) begin
			if (!prev_echo_q) begin
				dur_d = drus_pkg::TIMER_W'(1);
			end else if (dur_q != drus_pkg::TIMER_MAX) begin
				dur_d = dur_q + 1'b1;
			end
		end else if (prev_echo_q && await_q) begin
			if (side_right_q) begin
				right_d    = new_range;
				right_ok_d = 1'b1;
			end else begin
				left_d    = new_range;
				left_ok_d = 1'b1;
			end
			await_d = 1'b0;
		end
		prev_echo_d = echo;

		// timeout once the pulse is over
		if (await_d && pulse_q == '0) begin
			if (since_trig_q >= cfg.echo_timeout) begin
				if (side_right_q) begin
					right_d    = '0;
					right_ok_d = 1'b0;
				end else begin
					left_d    = '0;
					left_ok_d = 1'b0;
				end
				await_d = 1'b0;
			end else if (since_trig_q != drus_pkg::TIMER_MAX) begin
				since_trig_d = since_trig_q + 1'b1;
			end
		end

		// ping decision
		if (since_ping_q != drus_pkg::PING_MAX) begin
			since_ping_d = since_ping_q + 1'b1;
		end
		if (!await_d && pulse_q == '0 && since_ping_d >= interval) begin
			since_ping_d = '0;
			since_trig_d = '0;
			pulse_d      = drus_pkg::PULSE_W'(TRIGGER_PULSE_TICKS);
			await_d      = 1'b1;
			side_right_d = next_right_q;
			next_right_d = !next_right_q;
		end

		// trigger lines
		if (pulse_d != '0) begin
			tr      = side_right_d;
			tl      = !side_right_d;
			pulse_d = pulse_d - 1'b1;
		end
	end

	always_comb begin
		res.trig_left    = tl;
		res.trig_right   = tr;
		res.left_range   = left_d;
		res.left_valid   = left_ok_d;
		res.right_range  = right_d;
		res.right_valid  = right_ok_d;
		res.range_update = (left_d != left_q) || (right_d != right_q) ||
			(left_ok_d != left_ok_q) || (right_ok_d != right_ok_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			since_ping_q <= '0;
			since_trig_q <= '0;
			pulse_q      <= '0;
			await_q      <= 1'b0;
			side_right_q <= 1'b0;
			next_right_q <= 1'b0;
			prev_echo_q  <= 1'b0;
			dur_q        <= '0;
			left_q       <= '0;
			right_q      <= '0;
			left_ok_q    <= 1'b0;
			right_ok_q   <= 1'b0;
		end else if (step) begin
			since_ping_q <= since_ping_d;
			since_trig_q <= since_trig_d;
			pulse_q      <= pulse_d;
			await_q      <= await_d;
			side_right_q <= side_right_d;
			next_right_q <= next_right_d;
			prev_echo_q  <= prev_echo_d;
			dur_q        <= dur_d;
			left_q       <= left_d;
			right_q      <= right_d;
			left_ok_q    <= left_ok_d;
			right_ok_q   <= right_ok_d;
		end
	end

	// only one side is triggered at a time
	a_one_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.trig_left && res.trig_right))
		else $error("both trigger lines high");

	// a running pulse always drives one trigger line
	a_pulse_drives: assert property (@(posedge clk) disable iff (!arst_n)
		(pulse_q != '0) |-> (res.trig_left || res.trig_right))
		else $error("trigger pulse running with both lines low");

	// an invalid side reads as zero
	a_left_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!left_ok_q |-> (left_q == '0))
		else $error("invalid left side holds a range");

	a_right_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!right_ok_q |-> (right_q == '0))
		else $error("invalid right side holds a range");

	// a new ping restarts the interval count
	a_ping_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !await_q && await_d) |=> (since_ping_q == '0))
		else $error("ping did not restart interval count");

endmodule

@@ src/dual_ultrasonic_ranger_scheduler_unit.sv @@
// top level of the dual ultrasonic ranger scheduler: handshake, registers, result stage
//
// one input word is one microsecond tick carrying the shared echo line level
// (echo_level on echo_valid/echo_ready); every word yields exactly one result word
// on result_valid/result_ready with both trigger line levels, both stored ranges
// (cm with fraction bits, zero while invalid), their valid flags and range_update
// the left and right triggers fire in turn for a fixed number of ticks, no sooner
// than ping_interval_us ticks after the previous trigger and never while an echo
// is still awaited; once the echo timeout has passed after the pulse an unanswered
// side goes invalid
// a word passes an input stage, then one pass of scheduler logic and the range multiply into
// the result register; one word is taken every cycle while result_ready stays high
// after reset both sides are invalid, left is pinged first, and the first trigger
// comes ping_interval_us ticks after reset; registers return to their defaults
// when the receiver stalls the result register holds its word, the input stage
// takes one more word and then echo_ready drops until the result is taken
// registers sit on a small apb port: ping_interval_us at 0x0, echo timeout at 0x4
module dual_ultrasonic_ranger_scheduler_unit #(
	parameter int TRIGGER_PULSE_TICKS = drus_pkg::TRIGGER_PULSE_TICKS_DEF,
	parameter int RANGE_FRACTION_BITS = drus_pkg::RANGE_FRACTION_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// tick input
	input  logic                         echo_valid,
	output logic                         echo_ready,
	input  logic                         echo_level,
	// result output
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         trig_left,
	output logic                         trig_right,
	output logic [drus_pkg::RANGE_W-1:0] left_range,
	output logic                         left_valid,
	output logic [drus_pkg::RANGE_W-1:0] right_range,
	output logic                         right_valid,
	output logic                         range_update,
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [drus_pkg::ADDR_W-1:0]  paddr,
	input  logic [drus_pkg::DATA_W-1:0]  pwdata,
	output logic [drus_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	drus_pkg::cfg_t     cfg_q;
	drus_pkg::reg_idx_t reg_idx;
	drus_pkg::result_t  res;
	drus_pkg::result_t  res_q;
	logic               valid_s1;
	logic               echo_s1;
	logic               res_valid_q;
	logic               advance;
	logic               cfg_write;

	// register file
	assign pready    = 1'b1;
	assign reg_idx   = drus_pkg::reg_idx_t'(paddr[2]);
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ping_interval <= drus_pkg::PING_RESET;
			cfg_q.echo_timeout  <= drus_pkg::TIMEOUT_RESET;
		end else if (cfg_write) begin
			unique case (reg_idx)
				drus_pkg::REG_PING_INTERVAL: begin
					cfg_q.ping_interval <= pwdata[drus_pkg::PING_W-1:0];
				end
				drus_pkg::REG_ECHO_TIMEOUT: begin
					cfg_q.echo_timeout <= pwdata[drus_pkg::TIMER_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			drus_pkg::REG_PING_INTERVAL: prdata = drus_pkg::DATA_W'(cfg_q.ping_interval);
			drus_pkg::REG_ECHO_TIMEOUT:  prdata = drus_pkg::DATA_W'(cfg_q.echo_timeout);
			default:                     prdata = '0;
		endcase
	end

	// the scheduler steps when the input stage holds a word and the result slot frees up
	assign advance    = valid_s1 && (!res_valid_q || result_ready);
	assign echo_ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (echo_valid && echo_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (echo_valid && echo_ready) begin
			echo_s1 <= echo_level;
		end
	end

	drus_sched #(
		.TRIGGER_PULSE_TICKS(TRIGGER_PULSE_TICKS),
		.RANGE_FRACTION_BITS(RANGE_FRACTION_BITS)
	) u_sched (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.echo  (echo_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign trig_left    = res_q.trig_left;
	assign trig_right   = res_q.trig_right;
	assign left_range   = res_q.left_range;
	assign left_valid   = res_q.left_valid;
	assign right_range  = res_q.right_range;
	assign right_valid  = res_q.right_valid;
	assign range_update = res_q.range_update;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench of the dual ultrasonic ranger scheduler
`timescale 1ns / 1ps

module testbench;

	// the range is the echo time in ticks, scaled up by the fraction bits, over 58
	localparam int SOUND_CM_DIV   = 58;
	localparam int SCALED_W       = drus_pkg::TIMER_W + drus_pkg::RANGE_FRACTION_BITS_DEF;
	localparam int QUIET_LIMIT    = 4000;
	localparam int MAX_REPORTED   = 10;
	localparam int DRAIN_CYCLES   = 4;

	logic                          clk          = 1'b0;
	logic                          arst_n       = 1'b0;
	logic                          echo_valid   = 1'b0;
	logic                          echo_ready;
	logic                          echo_level   = 1'b0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic                          trig_left;
	logic                          trig_right;
	logic [drus_pkg::RANGE_W-1:0]  left_range;
	logic                          left_valid;
	logic [drus_pkg::RANGE_W-1:0]  right_range;
	logic                          right_valid;
	logic                          range_update;
	logic                          psel         = 1'b0;
	logic                          penable      = 1'b0;
	logic                          pwrite       = 1'b0;
	logic [drus_pkg::ADDR_W-1:0]   paddr        = '0;
	logic [drus_pkg::DATA_W-1:0]   pwdata       = '0;
	logic [drus_pkg::DATA_W-1:0]   prdata;
	logic                          pready;

	dual_ultrasonic_ranger_scheduler_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.echo_valid   (echo_valid),
		.echo_ready   (echo_ready),
		.echo_level   (echo_level),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.trig_left    (trig_left),
		.trig_right   (trig_right),
		.left_range   (left_range),
		.left_valid   (left_valid),
		.right_range  (right_range),
		.right_valid  (right_valid),
		.range_update (range_update),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// scheduler prediction: own copy of registers and ranging state
	// ------------------------------------------------------------------
	drus_pkg::cfg_t                cfg = '{ping_interval: drus_pkg::PING_RESET,
	                                       echo_timeout: drus_pkg::TIMEOUT_RESET};
	logic [drus_pkg::PING_W-1:0]   ticks_since_ping = '0;
	logic [drus_pkg::TIMER_W-1:0]  ticks_since_trig = '0;
	logic [drus_pkg::PULSE_W-1:0]  pulse_left       = '0;
	logic                          wait_echo        = 1'b0;
	logic                          wait_right       = 1'b0;
	logic                          next_right       = 1'b0;
	logic                          echo_prev        = 1'b0;
	logic [drus_pkg::TIMER_W-1:0]  echo_len         = '0;
	logic [drus_pkg::RANGE_W-1:0]  store_l          = '0;
	logic [drus_pkg::RANGE_W-1:0]  store_r          = '0;
	logic                          ok_l             = 1'b0;
	logic                          ok_r             = 1'b0;

	// result words still due from the block, oldest first
	drus_pkg::result_t due_words[$];

	int  mismatch_count = 0;
	int  words_checked  = 0;
	int  quiet_cycles   = 0;
	// steady: no sender gaps and no receiver stalls, used for the steady stream
	bit  steady         = 1'b0;
	int  burst_left     = 0;
	int  stall_left     = 0;
	int  pattern_left   = 0;
	bit  choppy         = 1'b0;

	// one microsecond tick of the scheduler
	function automatic drus_pkg::result_t ranger_tick(input logic lvl);
		drus_pkg::result_t              w;
		logic [drus_pkg::RANGE_W-1:0]   was_l, was_r;
		logic                           was_okl, was_okr;
		logic [drus_pkg::PING_W-1:0]    spacing;
		logic [SCALED_W-1:0]            scaled;
		logic [drus_pkg::RANGE_W-1:0]   cm;

		was_l   = store_l;
		was_r   = store_r;
		was_okl = ok_l;
		was_okr = ok_r;

		// echo edge: rising restarts the count, falling ends an awaited measurement
		if (lvl) begin
			if (!echo_prev)
				echo_len = drus_pkg::TIMER_W'(1);
			else if (echo_len != drus_pkg::TIMER_MAX)
				echo_len = echo_len + 1'b1;
		end else if (echo_prev && wait_echo) begin
			scaled = {echo_len, {drus_pkg::RANGE_FRACTION_BITS_DEF{1'b0}}} /
			         SCALED_W'(SOUND_CM_DIV);
			cm = (scaled > drus_pkg::RANGE_MAX) ? drus_pkg::RANGE_MAX
			                                    : scaled[drus_pkg::RANGE_W-1:0];
			if (wait_right) begin
				store_r = cm;
				ok_r    = 1'b1;
			end else begin
				store_l = cm;
				ok_l    = 1'b1;
			end
			wait_echo = 1'b0;
		end
		echo_prev = lvl;

		// timeout only runs once the trigger pulse is over
		if (wait_echo && pulse_left == 0) begin
			if (ticks_since_trig >= cfg.echo_timeout) begin
				if (wait_right) begin
					store_r = '0;
					ok_r    = 1'b0;
				end else begin
					store_l = '0;
					ok_l    = 1'b0;
				end
				wait_echo = 1'b0;
			end else if (ticks_since_trig != drus_pkg::TIMER_MAX) begin
				ticks_since_trig = ticks_since_trig + 1'b1;
			end
		end

		// next ping, alternating sides; an interval of zero behaves as one
		if (ticks_since_ping != drus_pkg::PING_MAX)
			ticks_since_ping = ticks_since_ping + 1'b1;
		spacing = (cfg.ping_interval == 0) ? drus_pkg::PING_W'(1) : cfg.ping_interval;
		if (!wait_echo && pulse_left == 0 && ticks_since_ping >= spacing) begin
			ticks_since_ping = '0;
			ticks_since_trig = '0;
			pulse_left       = drus_pkg::PULSE_W'(drus_pkg::TRIGGER_PULSE_TICKS_DEF);
			wait_echo        = 1'b1;
			wait_right       = next_right;
			next_right       = ~next_right;
		end

		w.trig_left  = 1'b0;
		w.trig_right = 1'b0;
		if (pulse_left != 0) begin
			w.trig_right = wait_right;
			w.trig_left  = ~wait_right;
			pulse_left   = pulse_left - 1'b1;
		end
		w.left_range   = store_l;
		w.left_valid   = ok_l;
		w.right_range  = store_r;
		w.right_valid  = ok_r;
		w.range_update = (was_l != store_l) || (was_r != store_r) ||
		                 (was_okl != ok_l) || (was_okr != ok_r);
		return w;
	endfunction

	function automatic void flag_mismatch(input string what, input int unsigned want,
	                                      input int unsigned got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("mismatch at word %0d, %s: expected %0d, got %0d",
			         words_checked, what, want, got);
	endfunction

	function automatic void check_field(input string what, input int unsigned want,
	                                    input int unsigned got);
		if (want != got)
			flag_mismatch(what, want, got);
	endfunction

	// ------------------------------------------------------------------
	// result side: stall pattern and field by field comparison
	// ------------------------------------------------------------------

	// receiver alternates between calm stretches and choppy ones with short stalls
	always @(posedge clk) begin
		if (pattern_left == 0) begin
			choppy       = ($urandom_range(0, 2) != 0);
			pattern_left = $urandom_range(50, 400);
		end
		pattern_left--;
		if (stall_left != 0)
			stall_left--;
		else if (choppy && !steady && $urandom_range(0, 4) == 0)
			stall_left = $urandom_range(1, 12);
		result_ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		drus_pkg::result_t got, want;
		if (result_valid && result_ready) begin
			got = {trig_left, trig_right, left_range, left_valid,
			       right_range, right_valid, range_update};
			if (due_words.size() == 0) begin
				flag_mismatch("word with nothing due, left_range", 0, got.left_range);
			end else begin
				want = due_words.pop_front();
				check_field("trig_left",    want.trig_left,    got.trig_left);
				check_field("trig_right",   want.trig_right,   got.trig_right);
				check_field("left_range",   want.left_range,   got.left_range);
				check_field("left_valid",   want.left_valid,   got.left_valid);
				check_field("right_range",  want.right_range,  got.right_range);
				check_field("right_valid",  want.right_valid,  got.right_valid);
				check_field("range_update", want.range_update, got.range_update);
			end
			words_checked++;
		end
	end

	// watchdog: too long without any word moving on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (echo_valid && echo_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tick side and register port
	// ------------------------------------------------------------------

	// one tick word; sender works in bursts with random gaps in between
	task automatic send_tick(input logic lvl);
		int gap;
		if (!steady && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				echo_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		if (burst_left != 0)
			burst_left--;
		echo_valid <= 1'b1;
		echo_level <= lvl;
		do @(posedge clk); while (!echo_ready);
		due_words.push_back(ranger_tick(lvl));
	endtask

	// stop sending, let every due word come back, then let the block drain
	task automatic settle();
		echo_valid <= 1'b0;
		while (due_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_read(input drus_pkg::reg_idx_t idx,
	                        output logic [drus_pkg::DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register write only with the block idle, then read back
	task automatic set_register(input drus_pkg::reg_idx_t idx,
	                            input logic [drus_pkg::DATA_W-1:0] value);
		logic [drus_pkg::DATA_W-1:0] readback;
		logic [drus_pkg::DATA_W-1:0] held;
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			drus_pkg::REG_PING_INTERVAL: begin
				cfg.ping_interval = value[drus_pkg::PING_W-1:0];
				held = drus_pkg::DATA_W'(cfg.ping_interval);
			end
			default: begin
				cfg.echo_timeout = value[drus_pkg::TIMER_W-1:0];
				held = drus_pkg::DATA_W'(cfg.echo_timeout);
			end
		endcase
		apb_read(idx, readback);
		check_field("register readback", held, readback);
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// defaults after reset; with the long default interval an echo is never awaited
	task automatic test_after_reset();
		logic [drus_pkg::DATA_W-1:0] readback;
		apb_read(drus_pkg::REG_PING_INTERVAL, readback);
		check_field("ping interval default", drus_pkg::DATA_W'(drus_pkg::PING_RESET),
		            readback);
		apb_read(drus_pkg::REG_ECHO_TIMEOUT, readback);
		check_field("echo timeout default", drus_pkg::DATA_W'(drus_pkg::TIMEOUT_RESET),
		            readback);
		send_tick(1'b1);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	// left ping answered while its pulse still runs, then right ping that times out
	task automatic test_echo_during_pulse();
		set_register(drus_pkg::REG_PING_INTERVAL, 0);
		set_register(drus_pkg::REG_ECHO_TIMEOUT, 4);
		send_tick(1'b0);
		repeat (4) send_tick(1'b1);
		repeat (20) send_tick(1'b0);
	endtask

	// mostly well-formed echo pulses of random spacing and width, some line noise
	task automatic test_random_ranging(input logic [drus_pkg::DATA_W-1:0] interval,
	                                   input logic [drus_pkg::DATA_W-1:0] timeout,
	                                   input int n_ticks, input int low_max,
	                                   input int high_max);
		int sent;
		int low_run;
		int high_run;
		set_register(drus_pkg::REG_PING_INTERVAL, interval);
		set_register(drus_pkg::REG_ECHO_TIMEOUT, timeout);
		sent = 0;
		while (sent < n_ticks) begin
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 6)) begin
					send_tick(1'($urandom_range(0, 1)));
					sent++;
				end
			end else begin
				low_run  = $urandom_range(0, low_max);
				high_run = $urandom_range(1, high_max);
				repeat (low_run) send_tick(1'b0);
				repeat (high_run) send_tick(1'b1);
				sent += low_run + high_run;
			end
		end
	endtask

	// back to back ticks with no stalls: a long echo, then a ping left unanswered
	task automatic test_steady_stream();
		set_register(drus_pkg::REG_PING_INTERVAL, 1);
		set_register(drus_pkg::REG_ECHO_TIMEOUT, 30);
		steady = 1'b1;
		repeat (2) send_tick(1'b0);
		repeat (60) send_tick(1'b1);
		repeat (60) send_tick(1'b0);
		settle();
		steady = 1'b0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_after_reset();
		test_echo_during_pulse();
		test_random_ranging(40, 120, 260, 60, 200);
		// zero interval and zero timeout: pings back to back, abandoned as soon as their pulse ends
		test_random_ranging(0, 0, 200, 8, 12);
		test_random_ranging(1, 60000, 240, 40, 300);
		test_random_ranging(300, 25, 200, 80, 60);
		test_random_ranging(1000000, 1, 120, 20, 20);
		test_steady_stream();

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && due_words.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
